// ===== rtl/copa_pkg.sv =====
// ----------------------------------------------------------------------------
// COPA encryptor package
// Shared types, constants and the AES and GF(2^128) helper functions.
// ----------------------------------------------------------------------------
package copa_pkg;

    localparam int IN_DEPTH_DEF  = 2;
    localparam int OUT_DEPTH_DEF = 4;
    localparam int AES_ROUNDS    = 10;
    localparam int CFG_IDX_W     = 1;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BLOCK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HI = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LO = 1'b1;

    localparam logic [127:0] GF_POLY = 128'h87;

    typedef struct packed {
        logic        action;
        logic        fin;
        logic [63:0] hi;
        logic [63:0] lo;
    } t_item;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        is_tag;
        logic        eor;
    } t_result;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte 0 of a block sits in the top byte.
    function automatic logic [7:0] byte_of(input logic [127:0] v, input int b);
        return v[127-8*b -: 8];
    endfunction

    function automatic logic [127:0] gf_dbl(input logic [127:0] a);
        return {a[126:0], 1'b0} ^ (a[127] ? GF_POLY : 128'h0);
    endfunction

    function automatic logic [127:0] gf_tpl(input logic [127:0] a);
        return gf_dbl(a) ^ a;
    endfunction

    function automatic logic [127:0] gf_sev(input logic [127:0] a);
        return gf_dbl(gf_dbl(a)) ^ gf_tpl(a);
    endfunction

    function automatic logic [127:0] key_expand(input logic [127:0] rk, input logic [7:0] rcon);
        logic [31:0] t;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        t  = {SBOX[byte_of(rk, 13)] ^ rcon, SBOX[byte_of(rk, 14)],
              SBOX[byte_of(rk, 15)], SBOX[byte_of(rk, 12)]};
        w0 = rk[127:96] ^ t;
        w1 = rk[95:64] ^ w0;
        w2 = rk[63:32] ^ w1;
        w3 = rk[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // SubBytes, ShiftRows and, except in the last round, MixColumns.
    function automatic logic [127:0] aes_round(input logic [127:0] st, input logic last);
        logic [7:0]   tb [16];
        logic [127:0] r;
        logic [7:0]   a0;
        logic [7:0]   a1;
        logic [7:0]   a2;
        logic [7:0]   a3;
        logic [7:0]   s;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                tb[c*4+j] = SBOX[byte_of(st, ((c + j) % 4) * 4 + j)];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = tb[c*4];
            a1 = tb[c*4+1];
            a2 = tb[c*4+2];
            a3 = tb[c*4+3];
            s  = a0 ^ a1 ^ a2 ^ a3;
            if (!last) begin
                r[127-8*(c*4)   -: 8] = a0 ^ s ^ xt(a0 ^ a1);
                r[127-8*(c*4+1) -: 8] = a1 ^ s ^ xt(a1 ^ a2);
                r[127-8*(c*4+2) -: 8] = a2 ^ s ^ xt(a2 ^ a3);
                r[127-8*(c*4+3) -: 8] = a3 ^ s ^ xt(a3 ^ a0);
            end else begin
                r[127-8*(c*4)   -: 8] = a0;
                r[127-8*(c*4+1) -: 8] = a1;
                r[127-8*(c*4+2) -: 8] = a2;
                r[127-8*(c*4+3) -: 8] = a3;
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/copa_authenticated_encryptor_unit.sv =====
// Results: a plaintext block gives its ciphertext; on a final block the tag
// follows the ciphertext. A start item gives no result. Items are taken one at
// a time: a new item waits until the last one is through, set by the single
// iterative AES unit running one round per cycle.
// Reset: synchronous active-low i_rst_n clears the queues, key and all masks.
// ----------------------------------------------------------------------------
// COPA authenticated encryptor
// Item queue in front, AES sequencer behind it, result queue at the output.
// ----------------------------------------------------------------------------
module copa_authenticated_encryptor_unit
    import copa_pkg::*;
#(
    parameter int IN_DEPTH  = IN_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 i_action,
    input  logic [63:0]          i_block_hi,
    input  logic [63:0]          i_block_lo,
    input  logic                 i_final_block,
    output logic                 empty,
    input  logic                 pop,
    output logic [63:0]          o_out_hi,
    output logic [63:0]          o_out_lo,
    output logic                 o_is_tag,
    output logic                 o_end_of_run,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);
    logic [63:0]  r_key_hi;
    logic [63:0]  r_key_lo;
    t_item        w_in_item;
    t_item        w_head;
    logic         w_head_empty;
    logic         w_pop_item;
    logic [$clog2(IN_DEPTH+1)-1:0]  w_in_cnt;
    logic [$clog2(OUT_DEPTH+1)-1:0] w_out_cnt;
    logic         w_out_full;
    logic         w_room;
    logic         w_core_start;
    logic [127:0] w_core_block;
    t_core_sts    w_core_sts;
    logic [127:0] w_core_result;
    logic         w_res_push;
    t_result      w_res;
    t_result      w_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_KEY_HI: r_key_hi <= i_cfg_data;
                REG_KEY_LO: r_key_lo <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_in_item = '{action: i_action, fin: i_final_block,
                         hi: i_block_hi, lo: i_block_lo};

    copa_fifo #(.WIDTH($bits(t_item)), .DEPTH(IN_DEPTH)) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_in_item),
        .o_full  (full),
        .i_pop   (w_pop_item),
        .o_data  (w_head),
        .o_empty (w_head_empty),
        .o_count (w_in_cnt)
    );

    // A run may emit two results, so it starts only with two free slots.
    assign w_room = (int'(w_out_cnt) <= OUT_DEPTH - 2) && !w_out_full;

    copa_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (w_head),
        .i_item_valid  (!w_head_empty && (w_in_cnt != '0)),
        .o_item_pop    (w_pop_item),
        .i_room        (w_room),
        .o_core_start  (w_core_start),
        .o_core_block  (w_core_block),
        .i_core_sts    (w_core_sts),
        .i_core_result (w_core_result),
        .o_res_push    (w_res_push),
        .o_res         (w_res)
    );

    copa_aes u_aes (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_core_start),
        .i_block  (w_core_block),
        .i_key    ({r_key_hi, r_key_lo}),
        .o_sts    (w_core_sts),
        .o_result (w_core_result)
    );

    copa_fifo #(.WIDTH($bits(t_result)), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (w_out),
        .o_empty (empty),
        .o_count (w_out_cnt)
    );

    assign o_out_hi     = w_out.hi;
    assign o_out_lo     = w_out.lo;
    assign o_is_tag     = w_out.is_tag;
    assign o_end_of_run = w_out.eor;

endmodule

// ===== rtl/copa_fifo.sv =====
// ----------------------------------------------------------------------------
// COPA queue
// Small register queue used for the item queue and the result queue.
// ----------------------------------------------------------------------------
module copa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rd];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(w_wr) - CW'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/copa_aes.sv =====
// ----------------------------------------------------------------------------
// COPA AES unit
// Iterative AES-128 encryption, one round per cycle, keys expanded on the fly.
// ----------------------------------------------------------------------------
module copa_aes
    import copa_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_block,
    input  logic [127:0] i_key,
    output t_core_sts    o_sts,
    output logic [127:0] o_result
);
    logic [127:0] r_st;
    logic [127:0] r_rk;
    logic [7:0]   r_rcon;
    logic [3:0]   r_round;
    logic         r_busy;
    logic         r_done;
    logic [127:0] w_rk_n;
    logic         w_last;

    assign w_rk_n   = key_expand(r_rk, r_rcon);
    assign w_last   = (r_round == 4'(AES_ROUNDS));
    assign o_result = r_st;
    assign o_sts    = '{busy: r_busy, done: r_done};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_st    <= i_block ^ i_key;
            r_rk    <= i_key;
            r_rcon  <= 8'h01;
            r_round <= 4'd1;
        end else if (r_busy) begin
            r_st    <= aes_round(r_st, w_last) ^ w_rk_n;
            r_rk    <= w_rk_n;
            r_rcon  <= xt(r_rcon);
            r_round <= r_round + 4'd1;
        end
    end

endmodule

// ===== rtl/copa_back.sv =====
// ----------------------------------------------------------------------------
// COPA sequencer
// Takes classified items off the queue and runs the AES passes of each.
// ----------------------------------------------------------------------------
module copa_back
    import copa_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_item        i_item,
    input  logic         i_item_valid,
    output logic         o_item_pop,
    input  logic         i_room,
    output logic         o_core_start,
    output logic [127:0] o_core_block,
    input  t_core_sts    i_core_sts,
    input  logic [127:0] i_core_result,
    output logic         o_res_push,
    output t_result      o_res
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_L, ST_V, ST_X, ST_C, ST_T1, ST_T2
    } t_state;

    t_state       r_state, n_state;
    logic [127:0] r_l, n_l;
    logic [127:0] r_chain, n_chain;
    logic [127:0] r_im, n_im;
    logic [127:0] r_om, n_om;
    logic [127:0] r_cs, n_cs;
    logic [127:0] r_blk, n_blk;
    logic         r_fin, n_fin;
    logic [127:0] w_res;
    logic         w_done;
    logic [127:0] w_sev;

    assign w_res  = i_core_result;
    assign w_done = i_core_sts.done;
    assign w_sev  = gf_sev(r_om);

    always_comb begin
        n_state      = r_state;
        n_l          = r_l;
        n_chain      = r_chain;
        n_im         = r_im;
        n_om         = r_om;
        n_cs         = r_cs;
        n_blk        = r_blk;
        n_fin        = r_fin;
        o_item_pop   = 1'b0;
        o_core_start = 1'b0;
        o_core_block = '0;
        o_res_push   = 1'b0;
        o_res        = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_item_valid && i_room) begin
                    o_item_pop   = 1'b1;
                    o_core_start = 1'b1;
                    n_blk        = {i_item.hi, i_item.lo};
                    n_fin        = i_item.fin;
                    if (i_item.action == ACT_START) begin
                        n_state = ST_L;
                    end else begin
                        o_core_block = {i_item.hi, i_item.lo} ^ r_im;
                        n_cs         = r_cs ^ {i_item.hi, i_item.lo};
                        n_state      = ST_X;
                    end
                end
            end
            ST_L: begin
                if (w_done) begin
                    n_l          = w_res;
                    o_core_start = 1'b1;
                    o_core_block = r_blk ^ gf_tpl(gf_tpl(gf_tpl(gf_tpl(w_res))));
                    n_state      = ST_V;
                end
            end
            ST_V: begin
                if (w_done) begin
                    n_chain = w_res ^ r_l;
                    n_im    = gf_tpl(r_l);
                    n_om    = gf_dbl(r_l);
                    n_cs    = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_X: begin
                if (w_done) begin
                    n_chain      = w_res ^ r_chain;
                    o_core_start = 1'b1;
                    o_core_block = w_res ^ r_chain;
                    n_state      = ST_C;
                end
            end
            ST_C: begin
                if (w_done) begin
                    o_res_push = 1'b1;
                    o_res      = '{hi: w_res[127:64] ^ r_om[127:64],
                                   lo: w_res[63:0] ^ r_om[63:0],
                                   is_tag: 1'b0, eor: !r_fin};
                    if (!r_fin) begin
                        n_im    = gf_dbl(r_im);
                        n_om    = gf_dbl(r_om);
                        n_state = ST_IDLE;
                    end else begin
                        o_core_start = 1'b1;
                        o_core_block = r_cs ^ gf_tpl(r_im);
                        n_state      = ST_T1;
                    end
                end
            end
            ST_T1: begin
                if (w_done) begin
                    o_core_start = 1'b1;
                    o_core_block = w_res ^ r_chain;
                    n_state      = ST_T2;
                end
            end
            ST_T2: begin
                if (w_done) begin
                    o_res_push = 1'b1;
                    o_res      = '{hi: w_res[127:64] ^ w_sev[127:64],
                                   lo: w_res[63:0] ^ w_sev[63:0],
                                   is_tag: 1'b1, eor: 1'b1};
                    n_im       = gf_dbl(r_im);
                    n_om       = gf_dbl(r_om);
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_l     <= '0;
            r_chain <= '0;
            r_im    <= '0;
            r_om    <= '0;
            r_cs    <= '0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_l     <= n_l;
            r_chain <= n_chain;
            r_im    <= n_im;
            r_om    <= n_om;
            r_cs    <= n_cs;
            r_fin   <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
    end

`ifndef SYNTHESIS
    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_core_start |-> !i_core_sts.busy)
        else $error("AES unit restarted while busy");
    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_core_sts.done |-> r_state != ST_IDLE)
        else $error("AES result arrived with no run in progress");
    a_idle_core_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !i_core_sts.busy && !i_core_sts.done)
        else $error("AES unit active while sequencer idle");
    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_item_pop |=> !o_res_push)
        else $error("result pushed right after a new item started");
`endif

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// COPA encryptor testbench
// Drives nonce and plaintext beats with random flow control, predicts every
// ciphertext and tag with a behavioral AES-128 and mask model, and checks the
// results in order.
// ----------------------------------------------------------------------------
module tb_top
    import copa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_ITEMS = 500;

    typedef enum int {
        MODE_SLOW_SINK,
        MODE_SLOW_SOURCE,
        MODE_FULL_RATE
    } t_flow_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic                 i_action = ACT_START;
    logic [63:0]          i_block_hi = '0;
    logic [63:0]          i_block_lo = '0;
    logic                 i_final_block = 1'b0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [63:0]          o_out_hi;
    logic [63:0]          o_out_lo;
    logic                 o_is_tag;
    logic                 o_end_of_run;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_KEY_HI;
    logic [63:0]          i_cfg_data = '0;

    t_flow_mode flow_mode = MODE_SLOW_SINK;
    int         cycle_count = 0;

    copa_authenticated_encryptor_unit dut (.*);

    always #6 i_clk = ~i_clk;

    function automatic logic [7:0] byte_x2(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] field_x2(input logic [127:0] a);
        return {a[126:0], 1'b0} ^ (a[127] ? 128'h87 : 128'h0);
    endfunction

    function automatic logic [127:0] field_x3(input logic [127:0] a);
        return field_x2(a) ^ a;
    endfunction

    function automatic logic [127:0] aes128_encrypt(input logic [127:0] key,
                                                    input logic [127:0] pt);
        logic [127:0] rk;
        logic [127:0] st;
        logic [7:0]   sb [16];
        logic [7:0]   rc;
        logic [7:0]   s;
        logic [31:0]  w;
        rk = key;
        st = pt ^ rk;
        rc = 8'h01;
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
                for (int j = 0; j < 4; j++)
                    sb[c*4+j] = SBOX[st[127-8*(((c+j)%4)*4+j) -: 8]];
            for (int c = 0; c < 4; c++) begin
                s = sb[c*4] ^ sb[c*4+1] ^ sb[c*4+2] ^ sb[c*4+3];
                for (int j = 0; j < 4; j++) begin
                    if (r < 10)
                        st[127-8*(c*4+j) -: 8] = sb[c*4+j] ^ s
                            ^ byte_x2(sb[c*4+j] ^ sb[c*4+(j+1)%4]);
                    else
                        st[127-8*(c*4+j) -: 8] = sb[c*4+j];
                end
            end
            w = {SBOX[rk[23:16]] ^ rc, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
            rk[127:96] = rk[127:96] ^ w;
            rk[95:64]  = rk[95:64] ^ rk[127:96];
            rk[63:32]  = rk[63:32] ^ rk[95:64];
            rk[31:0]   = rk[31:0] ^ rk[63:32];
            rc = byte_x2(rc);
            st = st ^ rk;
        end
        return st;
    endfunction

    class copa_scoreboard;
        logic [127:0] key;
        logic [127:0] base_l;
        logic [127:0] chain;
        logic [127:0] in_mask;
        logic [127:0] out_mask;
        logic [127:0] sum;
        t_result      pending [$];
        int           mismatches;

        function new();
            key = '0; base_l = '0; chain = '0;
            in_mask = '0; out_mask = '0; sum = '0;
            mismatches = 0;
        endfunction

        function void set_key_word(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
            if (idx == REG_KEY_HI) key[127:64] = data;
            else key[63:0] = data;
        endfunction

        function void note_item(t_item it);
            logic [127:0] blk;
            logic [127:0] y;
            t_result      res;
            blk = {it.hi, it.lo};
            if (it.action == ACT_START) begin
                base_l = aes128_encrypt(key, '0);
                y = base_l;
                for (int i = 0; i < 4; i++) y = field_x3(y);
                chain    = aes128_encrypt(key, blk ^ y) ^ base_l;
                in_mask  = field_x3(base_l);
                out_mask = field_x2(base_l);
                sum      = '0;
                return;
            end
            chain = chain ^ aes128_encrypt(key, blk ^ in_mask);
            y = aes128_encrypt(key, chain) ^ out_mask;
            sum = sum ^ blk;
            res = '{hi: y[127:64], lo: y[63:0], is_tag: 1'b0, eor: !it.fin};
            pending.push_back(res);
            if (it.fin) begin
                y = aes128_encrypt(key, sum ^ field_x3(in_mask));
                y = aes128_encrypt(key, y ^ chain);
                y = y ^ field_x2(field_x2(out_mask)) ^ field_x3(out_mask);
                res = '{hi: y[127:64], lo: y[63:0], is_tag: 1'b1, eor: 1'b1};
                pending.push_back(res);
            end
            in_mask  = field_x2(in_mask);
            out_mask = field_x2(out_mask);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h_%h tag %b", got.hi, got.lo,
                             got.is_tag);
                return;
            end
            want = pending.pop_front();
            if (got != want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %h_%h tag %b eor %b, got %h_%h tag %b eor %b",
                             want.hi, want.lo, want.is_tag, want.eor,
                             got.hi, got.lo, got.is_tag, got.eor);
            end
        endfunction
    endclass

    copa_scoreboard sb = new();

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("copa_authenticated_encryptor_unit regression: fail");
            $finish;
        end
    end

    // Input and output beats are taken at the rising edge, before the block updates.
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full)
            sb.note_item('{action: i_action, fin: i_final_block,
                           hi: i_block_hi, lo: i_block_lo});
        if (i_rst_n && pop && !empty)
            sb.check_result('{hi: o_out_hi, lo: o_out_lo, is_tag: o_is_tag,
                              eor: o_end_of_run});
    end

    always @(negedge i_clk) begin
        case (flow_mode)
            MODE_SLOW_SINK:   pop <= ($urandom_range(99) >= 75);
            MODE_SLOW_SOURCE: pop <= ($urandom_range(99) >= 6);
            default:          pop <= 1'b1;
        endcase
    end

    task automatic send_item(logic act, logic fin, logic [63:0] hi, logic [63:0] lo);
        int idle_pct;
        idle_pct = (flow_mode == MODE_SLOW_SINK) ? 6 :
                   (flow_mode == MODE_SLOW_SOURCE) ? 75 : 0;
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push          <= 1'b1;
        i_action      <= act;
        i_final_block <= fin;
        i_block_hi    <= hi;
        i_block_lo    <= lo;
        do @(posedge i_clk); while (full);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        // A start beat produces no result, so give the sequencer time to finish.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_key(logic [63:0] hi, logic [63:0] lo);
        for (int i = 0; i < 2; i++) begin
            @(negedge i_clk);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= (i == 0) ? REG_KEY_HI : REG_KEY_LO;
            i_cfg_data  <= (i == 0) ? hi : lo;
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.set_key_word(i_cfg_index, i_cfg_data);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_traffic(int count);
        int sent;
        int nblk;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(9) == 0) begin
                // Stray beat: a block with no fresh start, or an extra start.
                send_item(1'($urandom_range(1)), 1'($urandom_range(1)), rand64(), rand64());
                sent++;
            end else begin
                send_item(ACT_START, 1'($urandom_range(1)), rand64(), rand64());
                nblk = $urandom_range(1, 6);
                for (int b = 0; b < nblk; b++)
                    send_item(ACT_BLOCK, b == nblk - 1, rand64(), rand64());
                sent += nblk + 1;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero key: blocks before any start run on the cleared state, and
        // a block after a final one continues the chain.
        send_item(ACT_BLOCK, 1'b0, '0, '0);
        send_item(ACT_BLOCK, 1'b1, '1, '1);
        send_item(ACT_BLOCK, 1'b1, 64'h0123456789abcdef, '0);
        wait_idle();

        write_key('1, '1);
        send_item(ACT_START, 1'b0, '1, '1);
        send_item(ACT_BLOCK, 1'b0, '1, '0);
        send_item(ACT_BLOCK, 1'b0, '0, '1);
        send_item(ACT_BLOCK, 1'b1, '1, '1);
        send_item(ACT_START, 1'b1, '0, '0);
        send_item(ACT_BLOCK, 1'b1, '0, '0);
        wait_idle();

        // Key change in the middle of a message.
        write_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
        send_item(ACT_START, 1'b0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        send_item(ACT_BLOCK, 1'b0, 64'h6bc1bee22e409f96, 64'he93d7e117393172a);
        wait_idle();
        write_key('0, '1);
        send_item(ACT_BLOCK, 1'b1, 64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51);
        wait_idle();

        for (int m = 0; m < 3; m++) begin
            flow_mode = t_flow_mode'(m);
            write_key(rand64(), rand64());
            random_traffic(RANDOM_ITEMS / 3);
            wait_idle();
        end

        @(negedge i_clk);
        push <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("copa_authenticated_encryptor_unit regression: pass");
        else
            $display("copa_authenticated_encryptor_unit regression: fail");
        $finish;
    end

endmodule
